### rtl/hkr_pkg.sv
// hkr_pkg: shared types, codes and constants for the hotkey remap engine
// no dependencies; used by hkr_seq and hotkey_remap_engine
`default_nettype none

package hkr_pkg;

    typedef enum logic [1:0] {
        KIND_PASS = 2'd0,
        KIND_KEY  = 2'd1,
        KIND_CMD  = 2'd2,
        KIND_LOAD = 2'd3
    } t_kind;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    localparam logic [7:0] KEY_CTRL  = 8'h11;
    localparam logic [7:0] KEY_SHIFT = 8'h10;
    localparam logic [7:0] KEY_ALT   = 8'h12;
    localparam logic [7:0] KEY_WIN   = 8'h5B;

    // emission slots, lowest first
    localparam int SLOTS          = 20;
    localparam int POS_REL_A      = 0;
    localparam int POS_PRS_B      = 4;
    localparam int POS_TGT_DN     = 8;
    localparam int POS_TGT_UP     = 9;
    localparam int POS_CMD        = 10;
    localparam int POS_REL_C      = 11;
    localparam int POS_PRS_D      = 15;
    localparam int POS_SINGLE     = 19;

    localparam int ENTRY_W = 40;

    typedef struct packed {
        logic        command;
        logic [7:0]  key_code;
        logic        key_released;
        logic        shift_held;
        logic        ctrl_held;
        logic        alt_held;
        logic        win_held;
        logic [3:0]  entry_index;
        logic [3:0]  entry_source_mods;
        logic [7:0]  entry_target_key;
        logic [3:0]  entry_target_mods;
        logic [15:0] entry_command_id;
    } t_in;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_key;
        logic        out_key_up;
        logic        out_extended;
        logic [15:0] out_command_id;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [7:0]  src_key;
        logic [3:0]  src_mods;
        logic [7:0]  tgt_key;
        logic [3:0]  tgt_mods;
        logic [15:0] cmd_id;
    } t_entry;

    typedef struct packed {
        logic [SLOTS-1:0] mask;
        logic [7:0]       tgt_key;
        logic [15:0]      cmd_id;
        t_kind            single_kind;
    } t_job;

    function automatic logic [7:0] mod_key(input logic [1:0] b);
        logic [7:0] k;
        unique case (b)
            2'd0: k = KEY_CTRL;
            2'd1: k = KEY_SHIFT;
            2'd2: k = KEY_ALT;
            default: k = KEY_WIN;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

### rtl/hkr_ram.sv
// hkr_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies
`default_nettype none

module hkr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire [WIDTH-1:0]                       i_wdata,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/hkr_seq.sv
// hkr_seq: result sequencer; walks the slot mask of a job, one result per cycle while i_out_ready is high
// depends on hkr_pkg; output register parts the job side from the result channel
`default_nettype none

module hkr_seq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  hkr_pkg::t_job       i_job,
    output logic                o_busy,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output hkr_pkg::t_out       o_out_data
);

    logic                      r_busy;
    logic                      r_ovalid;
    hkr_pkg::t_job             r_job;
    hkr_pkg::t_out             r_out;

    logic                      n_busy;
    logic                      n_ovalid;
    hkr_pkg::t_job             n_job;
    hkr_pkg::t_out             n_out;

    logic [4:0]                pos;
    logic [hkr_pkg::SLOTS-1:0] rest;
    logic                      slot_free;

    always_comb begin
        pos = 5'd0;
        for (int i = hkr_pkg::SLOTS - 1; i >= 0; i--) begin
            if (r_job.mask[i]) begin
                pos = 5'(i);
            end
        end
        rest      = r_job.mask;
        rest[pos] = 1'b0;
        slot_free = !r_ovalid || i_out_ready;
    end

    always_comb begin
        n_busy   = r_busy;
        n_ovalid = r_ovalid && !i_out_ready;
        n_job    = r_job;
        n_out    = r_out;
        if (i_start) begin
            n_busy = 1'b1;
            n_job  = i_job;
        end else if (r_busy && slot_free) begin
            n_ovalid           = 1'b1;
            n_job.mask         = rest;
            n_busy             = (rest != '0);
            n_out              = '0;
            n_out.kind         = hkr_pkg::KIND_KEY;
            n_out.last         = (rest == '0);
            if (int'(pos) < hkr_pkg::POS_PRS_B) begin
                n_out.out_key    = hkr_pkg::mod_key(pos[1:0]);
                n_out.out_key_up = 1'b1;
            end else if (int'(pos) < hkr_pkg::POS_TGT_DN) begin
                n_out.out_key    = hkr_pkg::mod_key(pos[1:0]);
            end else if (int'(pos) == hkr_pkg::POS_TGT_DN) begin
                n_out.out_key      = r_job.tgt_key;
                n_out.out_extended = 1'b1;
            end else if (int'(pos) == hkr_pkg::POS_TGT_UP) begin
                n_out.out_key      = r_job.tgt_key;
                n_out.out_key_up   = 1'b1;
                n_out.out_extended = 1'b1;
            end else if (int'(pos) == hkr_pkg::POS_CMD) begin
                n_out.kind           = hkr_pkg::KIND_CMD;
                n_out.out_command_id = r_job.cmd_id;
            end else if (int'(pos) < hkr_pkg::POS_PRS_D) begin
                n_out.out_key    = hkr_pkg::mod_key(2'(pos - 5'(hkr_pkg::POS_REL_C)));
                n_out.out_key_up = 1'b1;
            end else if (int'(pos) < hkr_pkg::POS_SINGLE) begin
                n_out.out_key    = hkr_pkg::mod_key(2'(pos - 5'(hkr_pkg::POS_PRS_D)));
            end else begin
                n_out.kind = r_job.single_kind;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
        r_job <= n_job;
        r_out <= n_out;
    end

    assign o_busy      = r_busy;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

### rtl/hotkey_remap_engine.sv
// hotkey_remap_engine: top level; scans the mapping table ram for a match
// depends on hkr_pkg, hkr_ram and hkr_seq
// a load or key-release transaction goes straight to the sequencer; a key press scans
// one table entry per cycle until a hit or the last entry, then one result per cycle
// (up to 10) while i_out_ready is high; the next transaction is taken when the
// sequencer has issued its last result. reset empties the table via per-entry valid bits
`default_nettype none

module hotkey_remap_engine #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  hkr_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output hkr_pkg::t_out  o_out_data
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    hkr_pkg::t_state       r_state, n_state;
    logic [CW-1:0]         r_addr, n_addr;
    logic [7:0]            r_key;
    logic [3:0]            r_held;
    logic                  r_rd_pend, n_rd_pend;
    logic                  r_rd_last, n_rd_last;
    logic                  r_rd_vld;
    logic [TABLE_ENTRIES-1:0] r_valid;

    logic                  accept;
    logic                  do_load;
    logic                  issue;
    logic [3:0]            held;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;
    hkr_pkg::t_entry       wentry;
    logic [hkr_pkg::ENTRY_W-1:0] rdata;
    hkr_pkg::t_entry       ent;
    logic                  hit;
    logic                  start;
    hkr_pkg::t_job         job;
    logic                  seq_busy;
    logic [3:0]            rel;
    logic [3:0]            prs;

    assign o_in_ready = (r_state == hkr_pkg::ST_IDLE) && !seq_busy;
    assign accept     = i_in_valid && o_in_ready;
    assign held       = {i_in_data.win_held, i_in_data.alt_held,
                         i_in_data.shift_held, i_in_data.ctrl_held};
    assign do_load    = accept && i_in_data.command &&
                        (int'(i_in_data.entry_index) < TABLE_ENTRIES);
    assign waddr      = AW'(i_in_data.entry_index);
    assign wentry     = '{src_key:  i_in_data.key_code,
                          src_mods: i_in_data.entry_source_mods,
                          tgt_key:  i_in_data.entry_target_key,
                          tgt_mods: i_in_data.entry_target_mods,
                          cmd_id:   i_in_data.entry_command_id};
    assign raddr      = r_addr[AW-1:0];
    assign issue      = (r_state == hkr_pkg::ST_SCAN) && (r_addr < CW'(TABLE_ENTRIES));

    hkr_ram #(
        .WIDTH (hkr_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (do_load),
        .i_waddr (waddr),
        .i_wdata (wentry),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        ent = r_rd_vld ? hkr_pkg::t_entry'(rdata) : '0;
        hit = r_rd_pend && (ent.src_key != 8'd0) && (ent.src_key == r_key) &&
              (ent.src_mods == r_held);
        rel = ent.src_mods & ~ent.tgt_mods;
        prs = ent.tgt_mods & ~ent.src_mods;
    end

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_rd_pend = 1'b0;
        n_rd_last = r_rd_last;
        start     = 1'b0;
        job       = '0;
        job.tgt_key = ent.tgt_key;
        job.cmd_id  = ent.cmd_id;
        job.single_kind = hkr_pkg::KIND_PASS;
        unique case (r_state)
            hkr_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_in_data.command) begin
                        start = 1'b1;
                        job.single_kind = hkr_pkg::KIND_LOAD;
                        job.mask[hkr_pkg::POS_SINGLE] = 1'b1;
                    end else if (i_in_data.key_released) begin
                        start = 1'b1;
                        job.mask[hkr_pkg::POS_SINGLE] = 1'b1;
                    end else begin
                        n_state = hkr_pkg::ST_SCAN;
                        n_addr  = '0;
                    end
                end
            end
            hkr_pkg::ST_SCAN: begin
                if (issue) begin
                    n_addr    = r_addr + CW'(1);
                    n_rd_pend = 1'b1;
                    n_rd_last = (r_addr == CW'(TABLE_ENTRIES - 1));
                end
                if (hit) begin
                    start   = 1'b1;
                    n_state = hkr_pkg::ST_IDLE;
                    if (ent.cmd_id != 16'd0) begin
                        job.mask[hkr_pkg::POS_REL_A +: 4] = ent.src_mods;
                        job.mask[hkr_pkg::POS_CMD]        = 1'b1;
                        job.mask[hkr_pkg::POS_PRS_D +: 4] = ent.src_mods & r_held;
                    end else begin
                        job.mask[hkr_pkg::POS_REL_A +: 4] = rel;
                        job.mask[hkr_pkg::POS_PRS_B +: 4] = prs;
                        job.mask[hkr_pkg::POS_TGT_DN]     = 1'b1;
                        job.mask[hkr_pkg::POS_TGT_UP]     = 1'b1;
                        job.mask[hkr_pkg::POS_REL_C +: 4] = prs;
                        job.mask[hkr_pkg::POS_PRS_D +: 4] = rel & r_held;
                    end
                end else if (r_rd_pend && r_rd_last) begin
                    start   = 1'b1;
                    n_state = hkr_pkg::ST_IDLE;
                    job.mask[hkr_pkg::POS_SINGLE] = 1'b1;
                end
            end
            default: n_state = hkr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hkr_pkg::ST_IDLE;
            r_rd_pend <= 1'b0;
            r_valid   <= '0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= n_rd_pend;
            if (do_load) begin
                r_valid[waddr] <= 1'b1;
            end
        end
        r_addr    <= n_addr;
        r_rd_last <= n_rd_last;
        r_rd_vld  <= r_valid[raddr];
        if (accept) begin
            r_key  <= i_in_data.key_code;
            r_held <= held;
        end
    end

    hkr_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_job       (job),
        .o_busy      (seq_busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
